// ===== hdl/gcc_pkg.sv =====
// Shared types and constants for the greedy coin change unit.
package gcc_pkg;

   localparam int DataWidth     = 16;
   localparam int StepWidth     = $clog2(DataWidth);
   localparam int NumRegs       = 4;
   localparam int CsrIndexWidth = 2;

   typedef logic [DataWidth-1:0] data_type;

   // Power-on denominations; entries past the register list read as unused.
   localparam data_type DenomReset [8] = '{
      16'd1, 16'd5, 16'd10, 16'd25, 16'd0, 16'd0, 16'd0, 16'd0
   };

   typedef struct packed {
      logic     valid;
      data_type value;
   } sort_tok_type;

   typedef struct packed {
      logic     valid;
      data_type rem;
   } div_tok_type;

   typedef struct packed {
      logic     used;
      data_type value;
      data_type count;
   } cell_stat_type;

   typedef enum logic [2:0] {
      StIdle,
      StSort,
      StStart,
      StDivide,
      StEmit
   } ctrl_state_type;

endpackage

// ===== hdl/gcc_channels_if.sv =====
// Request and response channel interfaces of the greedy coin change unit.
interface gcc_req_if;
   logic              valid;
   logic              ready;
   gcc_pkg::data_type amount;

   modport source (output valid, output amount, input ready);
   modport sink (input valid, input amount, output ready);
endinterface

interface gcc_rsp_if;
   logic              valid;
   logic              ready;
   gcc_pkg::data_type coin_value;
   gcc_pkg::data_type coin_count;
   gcc_pkg::data_type remainder;
   logic              exact;
   logic              last;

   modport source (
      output valid, output coin_value, output coin_count, output remainder,
      output exact, output last, input ready
   );
   modport sink (
      input valid, input coin_value, input coin_count, input remainder,
      input exact, input last, output ready
   );
endinterface

// ===== hdl/gcc_cell.sv =====
// One cell of the chain: sorted insertion slot plus a bit-serial divider.
module gcc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  gcc_pkg::sort_tok_type  sort_in,
   output gcc_pkg::sort_tok_type  sort_out,
   input  gcc_pkg::div_tok_type   div_in,
   output gcc_pkg::div_tok_type   div_out,
   output gcc_pkg::cell_stat_type stat
);

   logic                         held_valid_ff, held_valid_in;
   gcc_pkg::data_type            held_ff, held_in;
   gcc_pkg::sort_tok_type        sort_out_ff, sort_out_in;
   logic                         busy_ff, busy_in;
   logic [gcc_pkg::StepWidth-1:0] step_ff, step_in;
   gcc_pkg::data_type            part_ff, part_in;
   gcc_pkg::data_type            quot_ff, quot_in;
   gcc_pkg::data_type            count_ff, count_in;
   gcc_pkg::div_tok_type         div_out_ff, div_out_in;
   logic [gcc_pkg::DataWidth:0]  shifted;
   logic [gcc_pkg::DataWidth:0]  diff;
   logic                         fits;

   // The chain is kept in descending order, so a value walks down until it
   // meets a smaller entry, which it displaces, or an equal one, where it stops.
   always_comb begin
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      sort_out_in   = '0;
      if (clear) begin
         held_valid_in = 1'b0;
      end else if (sort_in.valid) begin
         if (!held_valid_ff) begin
            held_valid_in = 1'b1;
            held_in       = sort_in.value;
         end else if (sort_in.value > held_ff) begin
            held_in           = sort_in.value;
            sort_out_in.valid = 1'b1;
            sort_out_in.value = held_ff;
         end else if (sort_in.value < held_ff) begin
            sort_out_in = sort_in;
         end
      end
   end

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      shifted = {part_ff, quot_ff[gcc_pkg::DataWidth-1]};
      diff    = shifted - {1'b0, held_ff};
      fits    = (shifted >= {1'b0, held_ff});
   end

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      part_in    = part_ff;
      quot_in    = quot_ff;
      count_in   = count_ff;
      div_out_in = '0;
      if (clear) begin
         busy_in  = 1'b0;
         count_in = '0;
      end else if (div_in.valid) begin
         if (held_valid_ff) begin
            busy_in = 1'b1;
            step_in = '0;
            part_in = '0;
            quot_in = div_in.rem;
         end else begin
            count_in   = '0;
            div_out_in = div_in;
         end
      end else if (busy_ff) begin
         part_in = fits ? diff[gcc_pkg::DataWidth-1:0]
                        : shifted[gcc_pkg::DataWidth-1:0];
         quot_in = {quot_ff[gcc_pkg::DataWidth-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == gcc_pkg::StepWidth'(gcc_pkg::DataWidth - 1)) begin
            busy_in          = 1'b0;
            count_in         = quot_in;
            div_out_in.valid = 1'b1;
            div_out_in.rem   = part_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         sort_out_ff   <= '0;
         busy_ff       <= 1'b0;
         div_out_ff    <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         sort_out_ff   <= sort_out_in;
         busy_ff       <= busy_in;
         div_out_ff    <= div_out_in;
      end
      held_ff  <= held_in;
      step_ff  <= step_in;
      part_ff  <= part_in;
      quot_ff  <= quot_in;
      count_ff <= count_in;
   end

   assign sort_out   = sort_out_ff;
   assign div_out    = div_out_ff;
   assign stat.used  = held_valid_ff && (count_ff != '0);
   assign stat.value = held_ff;
   assign stat.count = count_ff;

   a_busy_needs_value: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> held_valid_ff)
      else $error("cell divides without a denomination");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      div_out_ff.valid |-> !busy_ff)
      else $error("cell hands on a remainder while still dividing");

endmodule

// ===== hdl/gcc_ctrl.sv =====
// Sequencer: feeds the chain, starts the division pass and emits results.
module gcc_ctrl #(
   parameter int NUM_DENOMS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   gcc_req_if.sink                req_ch,
   gcc_rsp_if.source              rsp_ch,
   input  gcc_pkg::data_type      denom [NUM_DENOMS],
   input  gcc_pkg::cell_stat_type stat [NUM_DENOMS],
   input  gcc_pkg::div_tok_type   div_done,
   output logic                   clear,
   output gcc_pkg::sort_tok_type  sort_feed,
   output gcc_pkg::div_tok_type   div_start
);

   localparam int CntW = $clog2(2 * NUM_DENOMS);
   localparam int IdxW = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;

   gcc_pkg::ctrl_state_type state_ff, state_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   gcc_pkg::data_type       amount_ff, amount_in;
   gcc_pkg::data_type       final_rem_ff, final_rem_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   gcc_pkg::data_type       rsp_value_ff, rsp_value_in;
   gcc_pkg::data_type       rsp_count_ff, rsp_count_in;
   gcc_pkg::data_type       rsp_rem_ff, rsp_rem_in;
   logic                    rsp_exact_ff, rsp_exact_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_take;
   logic                    sort_done;
   logic [NUM_DENOMS-1:0]   used;
   logic [NUM_DENOMS-1:0]   below;
   logic                    any_used;
   logic                    more_below;
   gcc_pkg::cell_stat_type  sel;
   gcc_pkg::data_type       feed_value;
   logic                    out_free;
   logic                    load;
   logic                    load_last;

   always_comb begin
      feed_value = '0;
      sel        = '0;
      for (int i = 0; i < NUM_DENOMS; i++) begin
         used[i]  = stat[i].used;
         below[i] = (IdxW'(i) < idx_ff);
         if (cnt_ff == CntW'(i)) begin
            feed_value = denom[i];
         end
         if (idx_ff == IdxW'(i)) begin
            sel = stat[i];
         end
      end
      any_used   = |used;
      more_below = |(used & below);
   end

   assign req_take  = req_ch.valid && req_ch.ready;
   assign sort_done = (cnt_ff == CntW'(2 * NUM_DENOMS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gcc_pkg::StIdle: begin
            if (req_take) state_in = gcc_pkg::StSort;
         end
         gcc_pkg::StSort: begin
            if (sort_done) state_in = gcc_pkg::StStart;
         end
         gcc_pkg::StStart: begin
            state_in = gcc_pkg::StDivide;
         end
         gcc_pkg::StDivide: begin
            if (div_done.valid) state_in = gcc_pkg::StEmit;
         end
         gcc_pkg::StEmit: begin
            if (load && load_last) state_in = gcc_pkg::StIdle;
         end
         default: state_in = gcc_pkg::StIdle;
      endcase
   end

   // Outputs toward the channels and the chain.
   always_comb begin
      req_ch.ready    = (state_ff == gcc_pkg::StIdle);
      clear           = req_take;
      sort_feed.valid = (state_ff == gcc_pkg::StSort) && (cnt_ff < CntW'(NUM_DENOMS))
                        && (feed_value != '0);
      sort_feed.value = feed_value;
      div_start.valid = (state_ff == gcc_pkg::StStart);
      div_start.rem   = amount_ff;
      load            = (state_ff == gcc_pkg::StEmit) && out_free
                        && (!any_used || sel.used);
      load_last       = !any_used || !more_below;
   end

   // Datapath registers.
   always_comb begin
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      amount_in    = amount_ff;
      final_rem_in = final_rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_exact_in = rsp_exact_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_take) begin
         amount_in = req_ch.amount;
         cnt_in    = '0;
      end
      if (state_ff == gcc_pkg::StSort) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (div_done.valid) begin
         final_rem_in = div_done.rem;
         idx_in       = IdxW'(NUM_DENOMS - 1);
      end
      if ((state_ff == gcc_pkg::StEmit) && any_used && (!sel.used || load)) begin
         idx_in = idx_ff - 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = any_used ? sel.value : '0;
         rsp_count_in = any_used ? sel.count : '0;
         rsp_rem_in   = load_last ? final_rem_ff : '0;
         rsp_exact_in = load_last && (final_rem_ff == '0);
         rsp_last_in  = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcc_pkg::StIdle;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      amount_ff    <= amount_in;
      final_rem_ff <= final_rem_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_exact_ff <= rsp_exact_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.coin_value = rsp_value_ff;
   assign rsp_ch.coin_count = rsp_count_ff;
   assign rsp_ch.remainder  = rsp_rem_ff;
   assign rsp_ch.exact      = rsp_exact_ff;
   assign rsp_ch.last       = rsp_last_ff;

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done.valid |-> (state_ff == gcc_pkg::StDivide))
      else $error("division pass finished outside the divide phase");

   a_exact_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exact_ff) |-> (rsp_last_ff && (rsp_rem_ff == '0)))
      else $error("exact flag on a result that is not a clean final one");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (load && !load_last) |=> (state_ff == gcc_pkg::StEmit))
      else $error("left the emit phase with results still pending");

endmodule

// ===== hdl/greedy_coin_change_unit.sv =====
// Top level of the greedy coin change unit: registers, cell chain and sequencer.
//
//   Channel   Direction  Handshake        Carries
//   req_ch    in         valid / ready    amount
//   rsp_ch    out        valid / ready    coin_value, coin_count, remainder, exact, last
//   csr_*     in         csr_we only      denomination register writes
//
// One amount at a time: insertion into the sorted chain, then a bit-serial division
// in each cell that holds a denomination, while an empty cell passes the remainder on,
// then a scan of the cells on output.
// Reset is synchronous and restores the power-on denominations.
// A stalled response only delays the emit phase; req_ch is ready again once the
// last result of an amount is in the output register.
module greedy_coin_change_unit #(
   parameter int NUM_DENOMS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   gcc_req_if.sink                             req_ch,
   gcc_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [gcc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  gcc_pkg::data_type                   csr_wdata
);

   gcc_pkg::data_type      denom [NUM_DENOMS];
   gcc_pkg::cell_stat_type stat [NUM_DENOMS];
   gcc_pkg::sort_tok_type  sort_tok [NUM_DENOMS+1];
   gcc_pkg::div_tok_type   div_tok [NUM_DENOMS+1];
   logic                   clear;

   for (genvar i = 0; i < NUM_DENOMS; i++) begin : g_denom
      if (i < gcc_pkg::NumRegs) begin : g_reg
         gcc_pkg::data_type denom_ff, denom_in;

         always_comb begin
            denom_in = denom_ff;
            if (csr_we && (csr_index == gcc_pkg::CsrIndexWidth'(i))) begin
               denom_in = csr_wdata;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               denom_ff <= gcc_pkg::DenomReset[i];
            end else begin
               denom_ff <= denom_in;
            end
         end

         assign denom[i] = denom_ff;
      end else begin : g_unused
         assign denom[i] = '0;
      end
   end

   for (genvar i = 0; i < NUM_DENOMS; i++) begin : g_cell
      gcc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear),
         .sort_in  (sort_tok[i]),
         .sort_out (sort_tok[i+1]),
         .div_in   (div_tok[i]),
         .div_out  (div_tok[i+1]),
         .stat     (stat[i])
      );
   end

   gcc_ctrl #(
      .NUM_DENOMS (NUM_DENOMS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .denom     (denom),
      .stat      (stat),
      .div_done  (div_tok[NUM_DENOMS]),
      .clear     (clear),
      .sort_feed (sort_tok[0]),
      .div_start (div_tok[0])
   );

endmodule
